@@ rtl/gpid_pkg.sv @@
// Shared types, widths and reset values for the gain-scheduled PID unit.
`default_nettype none
package gpid_pkg;

  // Field widths.
  localparam int unsigned DataW  = 32;
  localparam int unsigned GainW  = 20;
  localparam int unsigned BoundW = 31;
  localparam int unsigned IdxW   = 3;

  // Register reset values.
  localparam logic [GainW-1:0]  CoarseKpRst = 20'd15360;
  localparam logic [GainW-1:0]  CoarseKiRst = 20'd256;
  localparam logic [GainW-1:0]  CoarseKdRst = 20'd76800;
  localparam logic [GainW-1:0]  FineKpRst   = 20'd3840;
  localparam logic [GainW-1:0]  FineKiRst   = 20'd0;
  localparam logic [GainW-1:0]  FineKdRst   = 20'd204800;
  localparam logic [BoundW-1:0] BandThrRst  = 31'd1966;
  localparam logic [BoundW-1:0] IntLimRst   = 31'd655360;

  // Register indexes.
  typedef enum logic [IdxW-1:0] {
    REG_COARSE_KP  = 3'd0,
    REG_COARSE_KI  = 3'd1,
    REG_COARSE_KD  = 3'd2,
    REG_FINE_KP    = 3'd3,
    REG_FINE_KI    = 3'd4,
    REG_FINE_KD    = 3'd5,
    REG_BAND_THR   = 3'd6,
    REG_INT_LIMIT  = 3'd7
  } cfg_reg_e;

  // Full configuration as seen by the datapath.
  typedef struct packed {
    logic [GainW-1:0]  coarse_kp;
    logic [GainW-1:0]  coarse_ki;
    logic [GainW-1:0]  coarse_kd;
    logic [GainW-1:0]  fine_kp;
    logic [GainW-1:0]  fine_ki;
    logic [GainW-1:0]  fine_kd;
    logic [BoundW-1:0] band_threshold;
    logic [BoundW-1:0] integral_limit;
  } cfg_t;

  // Contents of the stage register between the front and the back end.
  typedef struct packed {
    logic signed [DataW-1:0] err;
    logic signed [DataW:0]   diff;
    logic [GainW-1:0]        kp;
    logic [GainW-1:0]        ki;
    logic [GainW-1:0]        kd;
    logic                    fine;
  } stage_t;

endpackage
`default_nettype wire

@@ rtl/gain_scheduled_pid_unit.sv @@
// Top level of the gain-scheduled positional PID unit.
//
// Each input item carries a measured value and a target in signed Q16.16.
// Each accepted item yields exactly one result item: the saturated drive
// and three flags (fine band used, integral clamped, drive saturated).
// Both channels use valid/ready; an item moves when both are high. The eight
// gain and bound registers are written through a plain write port (enable,
// index, data); the user must write only while no item is in flight (unchecked).
//
// An accepted item passes the front end (error, band decision, gain
// selection) into the stage register, then the back end (three multipliers,
// integral clamp, drive sum) into the result register. Unless the receiver
// stalls, one item can be accepted every cycle; the integral add and clamp
// loop through the integral register in the back end, which sets that rate.
// When the receiver stalls, the result register holds its item and the
// front stage can still take one more item before input ready drops.
// Reset clears both stage valid flags, the previous error and the integral,
// and loads every configuration register with its default value.
`default_nettype none
module gain_scheduled_pid_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [gpid_pkg::DataW-1:0]  measured_i,
  input  wire logic signed [gpid_pkg::DataW-1:0]  target_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [gpid_pkg::DataW-1:0]       drive_o,
  output logic                                    fine_band_o,
  output logic                                    integral_clamped_o,
  output logic                                    drive_saturated_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [gpid_pkg::IdxW-1:0]          cfg_idx_i,
  input  wire logic [gpid_pkg::BoundW-1:0]        cfg_data_i
);

  gpid_pkg::cfg_t   cfg;
  gpid_pkg::stage_t stage;
  logic             stage_valid_q;
  logic             out_free, in_acc, stage_adv;

  // Pipeline flow control.
  assign out_free   = !out_valid_o || out_ready_i;
  assign stage_adv  = stage_valid_q && out_free;
  assign in_ready_o = !stage_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= in_acc || (stage_valid_q && !stage_adv);
    end
  end

  // Configuration registers.
  gpid_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Front end.
  gpid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_acc),
    .measured_i (measured_i),
    .target_i   (target_i),
    .cfg_i      (cfg),
    .stage_o    (stage)
  );

  // Back end and result register.
  gpid_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (stage_adv),
    .out_ready_i        (out_ready_i),
    .stage_i            (stage),
    .integral_limit_i   (cfg.integral_limit),
    .out_valid_o        (out_valid_o),
    .drive_o            (drive_o),
    .fine_band_o        (fine_band_o),
    .integral_clamped_o (integral_clamped_o),
    .drive_saturated_o  (drive_saturated_o)
  );

  // An empty front stage must always be able to take an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid_q |-> in_ready_o)
    else $error("input not ready with an empty front stage");

  // Taking an item into a full front stage requires it to move on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && stage_valid_q) |-> stage_adv)
    else $error("front stage overwritten before advancing");

  // An item leaving the front stage appears as a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_adv |=> out_valid_o)
    else $error("advanced item did not reach the result register");

  // A saturated drive sits at one of the two range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && drive_saturated_o) |->
      (drive_o == 32'sh7fffffff || drive_o == 32'sh80000000))
    else $error("saturated drive is not at a range limit");

endmodule
`default_nettype wire

@@ rtl/gpid_cfg.sv @@
// Configuration register file of the gain-scheduled PID unit.
`default_nettype none
module gpid_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [gpid_pkg::IdxW-1:0]    cfg_idx_i,
  input  wire logic [gpid_pkg::BoundW-1:0]  cfg_data_i,
  output gpid_pkg::cfg_t                    cfg_o
);

  gpid_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; gains keep only their low bits.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (gpid_pkg::cfg_reg_e'(cfg_idx_i))
        gpid_pkg::REG_COARSE_KP: cfg_d.coarse_kp      = cfg_data_i[gpid_pkg::GainW-1:0];
        gpid_pkg::REG_COARSE_KI: cfg_d.coarse_ki      = cfg_data_i[gpid_pkg::GainW-1:0];
        gpid_pkg::REG_COARSE_KD: cfg_d.coarse_kd      = cfg_data_i[gpid_pkg::GainW-1:0];
        gpid_pkg::REG_FINE_KP:   cfg_d.fine_kp        = cfg_data_i[gpid_pkg::GainW-1:0];
        gpid_pkg::REG_FINE_KI:   cfg_d.fine_ki        = cfg_data_i[gpid_pkg::GainW-1:0];
        gpid_pkg::REG_FINE_KD:   cfg_d.fine_kd        = cfg_data_i[gpid_pkg::GainW-1:0];
        gpid_pkg::REG_BAND_THR:  cfg_d.band_threshold = cfg_data_i;
        gpid_pkg::REG_INT_LIMIT: cfg_d.integral_limit = cfg_data_i;
      endcase
    end
  end

  // Register storage with the documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coarse_kp      <= gpid_pkg::CoarseKpRst;
      cfg_q.coarse_ki      <= gpid_pkg::CoarseKiRst;
      cfg_q.coarse_kd      <= gpid_pkg::CoarseKdRst;
      cfg_q.fine_kp        <= gpid_pkg::FineKpRst;
      cfg_q.fine_ki        <= gpid_pkg::FineKiRst;
      cfg_q.fine_kd        <= gpid_pkg::FineKdRst;
      cfg_q.band_threshold <= gpid_pkg::BandThrRst;
      cfg_q.integral_limit <= gpid_pkg::IntLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ rtl/gpid_front.sv @@
// Front end: error, band decision and gain selection into the stage register.
`default_nettype none
module gpid_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               load_i,
  input  wire logic signed [gpid_pkg::DataW-1:0]  measured_i,
  input  wire logic signed [gpid_pkg::DataW-1:0]  target_i,
  input  wire gpid_pkg::cfg_t                     cfg_i,
  output gpid_pkg::stage_t                        stage_o
);

  localparam int unsigned W = gpid_pkg::DataW;

  logic signed [W-1:0] prev_err_q;
  logic signed [W:0]   raw_err;
  logic signed [W-1:0] err;
  logic [W-1:0]        prev_mag;
  gpid_pkg::stage_t    stage_q, stage_d;

  // Error with saturation to the signed 32-bit range.
  always_comb begin
    raw_err = (W+1)'(target_i) - (W+1)'(measured_i);
    if (raw_err[W] != raw_err[W-1]) begin
      err = raw_err[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      err = raw_err[W-1:0];
    end
  end

  // Magnitude of the previous error; the most negative value gives 2^31.
  assign prev_mag = prev_err_q[W-1] ? (~prev_err_q + 1'b1) : prev_err_q;

  // Band decision, gain selection and the difference term.
  always_comb begin
    stage_d.err  = err;
    stage_d.diff = (W+1)'(err) - (W+1)'(prev_err_q);
    stage_d.fine = prev_mag < {1'b0, cfg_i.band_threshold};
    stage_d.kp   = stage_d.fine ? cfg_i.fine_kp : cfg_i.coarse_kp;
    stage_d.ki   = stage_d.fine ? cfg_i.fine_ki : cfg_i.coarse_ki;
    stage_d.kd   = stage_d.fine ? cfg_i.fine_kd : cfg_i.coarse_kd;
  end

  // Previous error is part of the controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (load_i) begin
      prev_err_q <= err;
    end
  end

  // Stage register carries payload only.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

@@ rtl/gpid_back.sv @@
// Back end: products, integral update, drive sum and the result register.
`default_nettype none
module gpid_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               load_i,
  input  wire logic                               out_ready_i,
  input  wire gpid_pkg::stage_t                   stage_i,
  input  wire logic [gpid_pkg::BoundW-1:0]        integral_limit_i,
  output logic                                    out_valid_o,
  output logic signed [gpid_pkg::DataW-1:0]       drive_o,
  output logic                                    fine_band_o,
  output logic                                    integral_clamped_o,
  output logic                                    drive_saturated_o
);

  localparam int unsigned W   = gpid_pkg::DataW;
  localparam int unsigned G   = gpid_pkg::GainW;
  localparam int unsigned PW  = G + 1 + W;   // gain times error
  localparam int unsigned DW  = G + 2 + W;   // gain times difference
  localparam int unsigned IW  = PW - 8 + 1;  // integral sum
  localparam int unsigned SW  = DW - 8 + 2;  // drive sum

  logic signed [W-1:0]    integral_q;
  logic signed [PW-1:0]   p_prod, i_prod;
  logic signed [DW-1:0]   d_prod;
  logic signed [PW-9:0]   p_sh, i_sh;
  logic signed [DW-9:0]   d_sh;
  logic signed [IW-1:0]   integ_sum, lim_pos, lim_neg;
  logic signed [W-1:0]    integ;
  logic                   iclamp;
  logic signed [SW-1:0]   drive_sum;
  logic signed [W-1:0]    drive;
  logic                   dsat;

  logic                   out_valid_q;
  logic signed [W-1:0]    drive_q;
  logic                   fine_q, iclamp_q, dsat_q;

  // Three independent products, each floored by 256.
  assign p_prod = $signed({1'b0, stage_i.kp}) * stage_i.err;
  assign i_prod = $signed({1'b0, stage_i.ki}) * stage_i.err;
  assign d_prod = $signed({1'b0, stage_i.kd}) * stage_i.diff;
  assign p_sh   = $signed(p_prod[PW-1:8]);
  assign i_sh   = $signed(i_prod[PW-1:8]);
  assign d_sh   = $signed(d_prod[DW-1:8]);

  // Integral accumulate and symmetric clamp.
  always_comb begin
    integ_sum = IW'(integral_q) + IW'(i_sh);
    lim_pos   = $signed({{(IW-gpid_pkg::BoundW){1'b0}}, integral_limit_i});
    lim_neg   = -lim_pos;
    iclamp    = 1'b0;
    if (integ_sum > lim_pos) begin
      integ  = lim_pos[W-1:0];
      iclamp = 1'b1;
    end else if (integ_sum < lim_neg) begin
      integ  = lim_neg[W-1:0];
      iclamp = 1'b1;
    end else begin
      integ = integ_sum[W-1:0];
    end
  end

  // Drive sum with saturation to the signed 32-bit range.
  always_comb begin
    drive_sum = SW'(p_sh) + SW'(d_sh) + SW'(integ);
    if (drive_sum > SW'($signed({1'b0, {(W-1){1'b1}}}))) begin
      drive = {1'b0, {(W-1){1'b1}}};
      dsat  = 1'b1;
    end else if (drive_sum < SW'($signed({1'b1, {(W-1){1'b0}}}))) begin
      drive = {1'b1, {(W-1){1'b0}}};
      dsat  = 1'b1;
    end else begin
      drive = drive_sum[W-1:0];
      dsat  = 1'b0;
    end
  end

  // Integral state and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      integral_q  <= integ;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q  <= drive;
      fine_q   <= stage_i.fine;
      iclamp_q <= iclamp;
      dsat_q   <= dsat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign drive_o            = drive_q;
  assign fine_band_o        = fine_q;
  assign integral_clamped_o = iclamp_q;
  assign drive_saturated_o  = dsat_q;

endmodule
`default_nettype wire

@@ tb/tb_gain_scheduled_pid_unit.sv @@
// Testbench for the gain-scheduled PID unit: stimulus, predictor and scoreboard.
`default_nettype none
module tb_gain_scheduled_pid_unit;
  import gpid_pkg::*;

  localparam int    CycleLimit = 200000;
  localparam int    PhaseItems = 83;
  localparam longint S32Max    = 64'sd2147483647;
  localparam longint S32Min    = -64'sd2147483648;

  typedef struct packed {
    logic signed [DataW-1:0] measured;
    logic signed [DataW-1:0] target;
  } pid_sample_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    fine_band;
    logic                    integral_clamped;
    logic                    drive_saturated;
  } pid_result_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid    = 1'b0;
  logic signed [DataW-1:0] in_measured = '0;
  logic signed [DataW-1:0] in_target   = '0;
  logic                    out_ready   = 1'b0;
  logic                    cfg_we      = 1'b0;
  logic [IdxW-1:0]         cfg_idx     = '0;
  logic [BoundW-1:0]       cfg_data    = '0;
  logic                    calm        = 1'b0;

  logic                    in_ready_o;
  logic                    out_valid_o;
  logic signed [DataW-1:0] drive_o;
  logic                    fine_band_o;
  logic                    integral_clamped_o;
  logic                    drive_saturated_o;

  pid_sample_t sample_q[$];
  pid_result_t drive_exp_q[$];
  int          n_fail = 0;
  int          cycles = 0;

  // Predictor copy of the gain and bound registers.
  logic [GainW-1:0]  p_coarse_kp = CoarseKpRst;
  logic [GainW-1:0]  p_coarse_ki = CoarseKiRst;
  logic [GainW-1:0]  p_coarse_kd = CoarseKdRst;
  logic [GainW-1:0]  p_fine_kp   = FineKpRst;
  logic [GainW-1:0]  p_fine_ki   = FineKiRst;
  logic [GainW-1:0]  p_fine_kd   = FineKdRst;
  logic [BoundW-1:0] p_band_thr  = BandThrRst;
  logic [BoundW-1:0] p_int_lim   = IntLimRst;

  // Predictor copy of the controller state.
  logic signed [DataW-1:0] last_err = '0;
  logic signed [DataW-1:0] acc_sum  = '0;

  gain_scheduled_pid_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .measured_i         (in_measured),
    .target_i           (in_target),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .drive_o            (drive_o),
    .fine_band_o        (fine_band_o),
    .integral_clamped_o (integral_clamped_o),
    .drive_saturated_o  (drive_saturated_o),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // One control step: pick the gain set, update the integral and form the drive.
  function automatic pid_result_t pid_advance(input logic signed [DataW-1:0] meas,
                                              input logic signed [DataW-1:0] targ);
    pid_result_t r;
    longint      prev, mag, thr, lim, err, kp, ki, kd, acc, drv;
    logic        fine;
    prev = longint'(last_err);
    mag  = (prev < 0) ? -prev : prev;
    thr  = longint'(p_band_thr);
    lim  = longint'(p_int_lim);
    fine = (mag < thr);
    kp   = longint'(fine ? p_fine_kp : p_coarse_kp);
    ki   = longint'(fine ? p_fine_ki : p_coarse_ki);
    kd   = longint'(fine ? p_fine_kd : p_coarse_kd);
    err  = longint'(targ) - longint'(meas);
    if (err > S32Max) err = S32Max;
    else if (err < S32Min) err = S32Min;
    acc = longint'(acc_sum) + ((ki * err) >>> 8);
    r.integral_clamped = 1'b0;
    if (acc > lim) begin
      acc = lim;
      r.integral_clamped = 1'b1;
    end else if (acc < -lim) begin
      acc = -lim;
      r.integral_clamped = 1'b1;
    end
    drv = ((kp * err) >>> 8) + ((kd * (err - prev)) >>> 8) + acc;
    r.drive_saturated = 1'b1;
    if (drv > S32Max) drv = S32Max;
    else if (drv < S32Min) drv = S32Min;
    else r.drive_saturated = 1'b0;
    r.drive     = drv[DataW-1:0];
    r.fine_band = fine;
    last_err    = err[DataW-1:0];
    acc_sum     = acc[DataW-1:0];
    return r;
  endfunction

  // Input driver: predicts on each accepted item and presents the next one.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    pid_sample_t pend;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        drive_exp_q.push_back(pid_advance(in_measured, in_target));
      end
      if (!in_valid || in_ready_o) begin
        if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
          pend = sample_q.pop_front();
          in_valid    <= 1'b1;
          in_measured <= pend.measured;
          in_target   <= pend.target;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pid_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (drive_exp_q.size() == 0) begin
          $display("%0t: result with none expected, drive %0d", $time, drive_o);
          n_fail++;
        end else begin
          want = drive_exp_q.pop_front();
          if (want.drive !== drive_o) begin
            $display("%0t: drive expected %0d got %0d", $time, want.drive, drive_o);
            n_fail++;
          end
          if (want.fine_band !== fine_band_o) begin
            $display("%0t: fine_band expected %0b got %0b", $time, want.fine_band,
                     fine_band_o);
            n_fail++;
          end
          if (want.integral_clamped !== integral_clamped_o) begin
            $display("%0t: integral_clamped expected %0b got %0b", $time,
                     want.integral_clamped, integral_clamped_o);
            n_fail++;
          end
          if (want.drive_saturated !== drive_saturated_o) begin
            $display("%0t: drive_saturated expected %0b got %0b", $time,
                     want.drive_saturated, drive_saturated_o);
            n_fail++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Writes one register and mirrors it into the predictor; gains keep only their low bits.
  task automatic write_reg(input cfg_reg_e idx, input logic [BoundW-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_COARSE_KP: p_coarse_kp = val[GainW-1:0];
      REG_COARSE_KI: p_coarse_ki = val[GainW-1:0];
      REG_COARSE_KD: p_coarse_kd = val[GainW-1:0];
      REG_FINE_KP:   p_fine_kp   = val[GainW-1:0];
      REG_FINE_KI:   p_fine_ki   = val[GainW-1:0];
      REG_FINE_KD:   p_fine_kd   = val[GainW-1:0];
      REG_BAND_THR:  p_band_thr  = val;
      REG_INT_LIMIT: p_int_lim   = val;
      default: ;
    endcase
  endtask

  // Writes all eight registers, gains first, then the two bounds.
  task automatic write_all(input logic [BoundW-1:0] gain_val[6],
                           input logic [BoundW-1:0] thr, input logic [BoundW-1:0] lim);
    for (int i = 0; i < 6; i++) write_reg(cfg_reg_e'(i), gain_val[i]);
    write_reg(REG_BAND_THR, thr);
    write_reg(REG_INT_LIMIT, lim);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BoundW-1:0] rand_gain();
    case ($urandom_range(3))
      0:       return BoundW'($urandom_range(512));
      1:       return BoundW'($urandom_range(65536));
      2:       return BoundW'($urandom & 32'hFFFFF);
      default: return BoundW'($urandom);  // upper bits may be set, dropped by the register
    endcase
  endfunction

  function automatic logic [BoundW-1:0] rand_bound();
    case ($urandom_range(4))
      0:       return BoundW'($urandom_range(4096));
      1:       return BoundW'($urandom_range(1 << 20));
      2:       return BoundW'($urandom_range(1 << 28, 1 << 20));
      3:       return BoundW'($urandom);
      default: return '0;
    endcase
  endfunction

  task automatic push_sample(input logic signed [DataW-1:0] meas,
                             input logic signed [DataW-1:0] targ);
    pid_sample_t s;
    s.measured = meas;
    s.target   = targ;
    sample_q.push_back(s);
  endtask

  // Waits until every item has been taken and answered, then a short pause.
  task automatic drain();
    while (sample_q.size() != 0 || in_valid || drive_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [DataW-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      default: return -32'sd1;
    endcase
  endfunction

  // Random phase: mostly a loop tracking a setpoint, with noise and extremes mixed in.
  task automatic random_phase(input int n_items);
    logic [BoundW-1:0]       gains[6];
    logic signed [DataW-1:0] setpt;
    longint                  spread, off;
    int                      pick;
    for (int i = 0; i < 6; i++) gains[i] = rand_gain();
    write_all(gains, rand_bound(), rand_bound());
    spread = (p_band_thr < (1 << 23)) ? 2 * longint'(p_band_thr) + 16 : longint'(1 << 24);
    setpt  = $signed($urandom_range(1 << 31)) - (1 << 30);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 5) setpt = $signed($urandom_range(1 << 31)) - (1 << 30);
      if (pick < 60) begin
        off = longint'($urandom_range(32'(2 * spread))) - spread;
        push_sample(DataW'(setpt + off), setpt);
      end else if (pick < 90) begin
        push_sample($urandom, $urandom);
      end else begin
        push_sample(pick_extreme(), pick_extreme());
      end
    end
    drain();
  endtask

  initial begin : main
    logic [BoundW-1:0] gains[6];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains: zero error, field extremes, error overflow both ways,
    // the band threshold edge and a run into the negative integral clamp.
    push_sample(0, 0);
    push_sample(0, 1000);
    push_sample(0, 32'sh7FFF_FFFF);
    push_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
    push_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
    push_sample(32'sh8000_0000, 32'sh8000_0000);
    push_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_sample(-32'sd1, 0);
    push_sample(0, -32'sd1);
    push_sample(0, 1966);
    push_sample(0, 0);
    push_sample(0, 1965);
    push_sample(0, 0);
    for (int i = 0; i < 3; i++) push_sample(32'sd196608, 0);
    drain();

    // Every register at its maximum.
    for (int i = 0; i < 6; i++) gains[i] = 31'hFFFFF;
    write_all(gains, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    push_sample(0, 0);
    push_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
    push_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
    push_sample(0, 12345);
    drain();

    // Every register zero: the integral is held at zero and the band is empty.
    for (int i = 0; i < 6; i++) gains[i] = '0;
    write_all(gains, '0, '0);
    push_sample(0, 32'sh4000_0000);
    push_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
    push_sample(0, 0);
    drain();

    // Gain writes with bits above the register's width.
    for (int i = 0; i < 6; i++) gains[i] = {11'h7FF, 20'($urandom)} ;
    write_all(gains, 31'd65536, 31'd655360);
    push_sample(0, 32'sd70000);
    push_sample(0, 32'sd1000);
    push_sample(32'sd5000, 0);
    drain();

    // Random phases, one of them with no idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      calm <= (ph == 2);
      random_phase(PhaseItems);
    end
    calm <= 1'b0;
    repeat (10) @(posedge clk_i);

    if (n_fail == 0 && drive_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
